// ===== rtl/core/tro_pkg.sv =====
// ----------------------------------------------------------------------------
// tro_pkg
// Shared types, constants and sign helpers for the triangle/rectangle
// overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package tro_pkg;

    // Default coordinate width (signed fixed point)
    localparam int COORD_BITS = 16;

    // Exact sign of a value: both flags low means zero
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    // Strictly the same nonzero sign
    function automatic logic same_side(input t_sign a, input t_sign b);
        same_side = (a.pos & b.pos) | (a.neg & b.neg);
    endfunction

    // Strictly opposite nonzero signs
    function automatic logic opposite(input t_sign a, input t_sign b);
        opposite = (a.pos & b.neg) | (a.neg & b.pos);
    endfunction

    // Nonzero value
    function automatic logic nonzero(input t_sign a);
        nonzero = a.pos | a.neg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/triangle_rectangle_overlap_test.sv =====
// ----------------------------------------------------------------------------
// triangle_rectangle_overlap_test
// Reports whether a 2D triangle and an axis-aligned box overlap, using exact
// signs of cross products on signed fixed-point coordinates.
//
//   channel   signals                                   direction
//   request   i_in_valid / o_in_ready, i_tri_*, i_rect_* in
//   result    o_out_valid / i_out_ready, o_overlaps      out
//
// The request passes through the input register, then the result register;
// one request is taken every cycle while the result is not stalled.
// The path between the input and result registers is one multiplier pair
// plus a wide subtract in each cross-sign unit, then the sign logic.
// Reset clears both stage valid flags; payload registers are not reset.
// When the result is stalled the input stage still fills once, then
// o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_rectangle_overlap_test #(
    parameter int COORD_BITS = tro_pkg::COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_tri_ax,
    input  logic signed [COORD_BITS-1:0] i_tri_ay,
    input  logic signed [COORD_BITS-1:0] i_tri_bx,
    input  logic signed [COORD_BITS-1:0] i_tri_by,
    input  logic signed [COORD_BITS-1:0] i_tri_cx,
    input  logic signed [COORD_BITS-1:0] i_tri_cy,
    input  logic signed [COORD_BITS-1:0] i_rect_min_x,
    input  logic signed [COORD_BITS-1:0] i_rect_min_y,
    input  logic signed [COORD_BITS-1:0] i_rect_max_x,
    input  logic signed [COORD_BITS-1:0] i_rect_max_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_overlaps
);

    logic signed [COORD_BITS-1:0] r_tri_ax;
    logic signed [COORD_BITS-1:0] r_tri_ay;
    logic signed [COORD_BITS-1:0] r_tri_bx;
    logic signed [COORD_BITS-1:0] r_tri_by;
    logic signed [COORD_BITS-1:0] r_tri_cx;
    logic signed [COORD_BITS-1:0] r_tri_cy;
    logic signed [COORD_BITS-1:0] r_rect_min_x;
    logic signed [COORD_BITS-1:0] r_rect_min_y;
    logic signed [COORD_BITS-1:0] r_rect_max_x;
    logic signed [COORD_BITS-1:0] r_rect_max_y;
    logic                         r_in_valid;
    logic                         r_out_valid;
    logic                         r_overlaps;
    logic                         n_overlaps;
    logic                         out_advance;
    logic                         in_advance;

    // Stage handshake: each stage moves when the one after it has room
    assign out_advance = !r_out_valid || i_out_ready;
    assign in_advance  = !r_in_valid || out_advance;
    assign o_in_ready  = in_advance;
    assign o_out_valid = r_out_valid;
    assign o_overlaps  = r_overlaps;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_in_valid) begin
            r_tri_ax     <= i_tri_ax;
            r_tri_ay     <= i_tri_ay;
            r_tri_bx     <= i_tri_bx;
            r_tri_by     <= i_tri_by;
            r_tri_cx     <= i_tri_cx;
            r_tri_cy     <= i_tri_cy;
            r_rect_min_x <= i_rect_min_x;
            r_rect_min_y <= i_rect_min_y;
            r_rect_max_x <= i_rect_max_x;
            r_rect_max_y <= i_rect_max_y;
        end
    end

    // Overlap decision
    tro_overlap_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_ax(r_tri_ax),     .i_ay(r_tri_ay),
        .i_bx(r_tri_bx),     .i_by(r_tri_by),
        .i_cx(r_tri_cx),     .i_cy(r_tri_cy),
        .i_lx(r_rect_min_x), .i_ly(r_rect_min_y),
        .i_hx(r_rect_max_x), .i_hy(r_rect_max_y),
        .o_overlaps(n_overlaps)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_overlaps <= n_overlaps;
        end
    end

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    // A request in the input stage moves on when the result stage has room
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_advance |=> r_out_valid)
        else $error("request lost between stages");

    // A stalled input stage keeps its request
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_advance |=> r_in_valid && $stable(r_tri_ax)
        && $stable(r_rect_min_x) && $stable(r_rect_max_y))
        else $error("stalled request changed");

    // Vertex A inside the box always reports overlap
    a_vertex_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_advance && (r_tri_ax >= r_rect_min_x)
        && (r_tri_ax <= r_rect_max_x) && (r_tri_ay >= r_rect_min_y)
        && (r_tri_ay <= r_rect_max_y) |=> o_overlaps)
        else $error("vertex inside box not reported");

endmodule

`default_nettype wire

// ===== rtl/core/tro_cross_sign.sv =====
// ----------------------------------------------------------------------------
// tro_cross_sign
// Exact sign of the cross product (b - a) x (p - a), one multiplier pair
// followed by one wide subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tro_cross_sign #(
    parameter int COORD_BITS = tro_pkg::COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output tro_pkg::t_sign               o_sign
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    logic signed [DW-1:0] d_bx;
    logic signed [DW-1:0] d_by;
    logic signed [DW-1:0] d_px;
    logic signed [DW-1:0] d_py;
    logic signed [PW-1:0] prod_u;
    logic signed [PW-1:0] prod_v;
    logic signed [CW-1:0] cross_val;

    // Form exact differences, one bit wider than the coordinates
    assign d_bx = DW'(i_bx) - DW'(i_ax);
    assign d_by = DW'(i_by) - DW'(i_ay);
    assign d_px = DW'(i_px) - DW'(i_ax);
    assign d_py = DW'(i_py) - DW'(i_ay);

    // Full-width products, then their difference
    assign prod_u    = d_bx * d_py;
    assign prod_v    = d_px * d_by;
    assign cross_val = CW'(prod_u) - CW'(prod_v);

    // Reduce to a sign
    assign o_sign.neg = cross_val[CW-1];
    assign o_sign.pos = !cross_val[CW-1] && (cross_val != '0);

endmodule

`default_nettype wire

// ===== rtl/core/tro_overlap_core.sv =====
// ----------------------------------------------------------------------------
// tro_overlap_core
// Combinational overlap decision: vertex-in-box, min-corner-in-triangle
// and edge-crossing tests for the four box edges.
// ----------------------------------------------------------------------------
`default_nettype none

module tro_overlap_core #(
    parameter int COORD_BITS = tro_pkg::COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_lx,
    input  logic signed [COORD_BITS-1:0] i_ly,
    input  logic signed [COORD_BITS-1:0] i_hx,
    input  logic signed [COORD_BITS-1:0] i_hy,
    output logic                         o_overlaps
);

    logic signed [COORD_BITS-1:0] vx [3];
    logic signed [COORD_BITS-1:0] vy [3];
    logic signed [COORD_BITS-1:0] kx [4];
    logic signed [COORD_BITS-1:0] ky [4];

    tro_pkg::t_sign orient;
    tro_pkg::t_sign edge_sign [3][4];
    logic           side_ok   [3][4];
    tro_pkg::t_sign fsign     [4][3];
    logic           seg_span  [4];
    logic           seg_hit   [4];

    logic a_in_box;
    logic lo_in_tri;

    // Vertex and corner tables
    assign vx[0] = i_ax;  assign vy[0] = i_ay;
    assign vx[1] = i_bx;  assign vy[1] = i_by;
    assign vx[2] = i_cx;  assign vy[2] = i_cy;
    assign kx[0] = i_lx;  assign ky[0] = i_ly;
    assign kx[1] = i_lx;  assign ky[1] = i_hy;
    assign kx[2] = i_hx;  assign ky[2] = i_ly;
    assign kx[3] = i_hx;  assign ky[3] = i_hy;

    // Triangle orientation; equals the barycentric determinant
    tro_cross_sign #(.COORD_BITS(COORD_BITS)) u_orient (
        .i_ax(vx[0]), .i_ay(vy[0]),
        .i_bx(vx[1]), .i_by(vy[1]),
        .i_px(vx[2]), .i_py(vy[2]),
        .o_sign(orient)
    );

    // Side of each box corner against each triangle edge (AB, BC, CA)
    for (genvar e = 0; e < 3; e++) begin : g_edge
        for (genvar k = 0; k < 4; k++) begin : g_corner
            tro_cross_sign #(.COORD_BITS(COORD_BITS)) u_side (
                .i_ax(vx[e]), .i_ay(vy[e]),
                .i_bx(vx[(e + 1) % 3]), .i_by(vy[(e + 1) % 3]),
                .i_px(kx[k]), .i_py(ky[k]),
                .o_sign(edge_sign[e][k])
            );
            assign side_ok[e][k] = tro_pkg::same_side(edge_sign[e][k], orient);
        end
    end

    // Box edges are axis aligned: the side of a vertex reduces to a compare
    for (genvar v = 0; v < 3; v++) begin : g_vert
        assign fsign[0][v].pos = vx[v] > i_lx;
        assign fsign[0][v].neg = vx[v] < i_lx;
        assign fsign[1][v].pos = vy[v] > i_ly;
        assign fsign[1][v].neg = vy[v] < i_ly;
        assign fsign[2][v].pos = vy[v] > i_hy;
        assign fsign[2][v].neg = vy[v] < i_hy;
        assign fsign[3][v].pos = vx[v] > i_hx;
        assign fsign[3][v].neg = vx[v] < i_hx;
    end

    // A box edge of zero length has no side at all
    assign seg_span[0] = i_hy != i_ly;
    assign seg_span[1] = i_hx != i_lx;
    assign seg_span[2] = i_hx != i_lx;
    assign seg_span[3] = i_hy != i_ly;

    // Edge crossing: triangle not wholly on one side, and some endpoint
    // on the inner side of each triangle edge
    for (genvar s = 0; s < 4; s++) begin : g_seg
        // Box edges by corner index (lo, upper-left, lower-right, hi)
        localparam int P0 = (s < 2) ? 0 : 3;
        localparam int P1 = 1 + (s % 2);
        logic all_one_side;
        assign all_one_side = seg_span[s]
                            & tro_pkg::same_side(fsign[s][0], fsign[s][1])
                            & tro_pkg::same_side(fsign[s][0], fsign[s][2]);
        assign seg_hit[s] = !all_one_side
                          & (side_ok[0][P0] | side_ok[0][P1])
                          & (side_ok[1][P0] | side_ok[1][P1])
                          & (side_ok[2][P0] | side_ok[2][P1]);
    end

    // Vertex A inside the box, bounds inclusive
    assign a_in_box = (i_ax >= i_lx) && (i_ax <= i_hx) && (i_ay >= i_ly) && (i_ay <= i_hy);

    // Min corner inside the triangle; zero numerators pass, flat triangle fails
    assign lo_in_tri = tro_pkg::nonzero(orient)
                     && !tro_pkg::opposite(edge_sign[1][0], orient)
                     && !tro_pkg::opposite(edge_sign[2][0], orient)
                     && !tro_pkg::opposite(edge_sign[0][0], orient);

    assign o_overlaps = a_in_box | lo_in_tri | seg_hit[0] | seg_hit[1] | seg_hit[2] | seg_hit[3];

endmodule

`default_nettype wire

// ===== sim/triangle_rectangle_overlap_test_test.sv =====
// ----------------------------------------------------------------------------
// triangle_rectangle_overlap_test_test
// Streams triangle/box pairs through the overlap tester and checks every
// overlap flag against an exact integer predictor kept in the bench. Both
// handshakes idle at random. There are steady stretches, a long result
// stall that backs up the input, and bursts that drain fully between them.
// ----------------------------------------------------------------------------

module triangle_rectangle_overlap_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW            = tro_pkg::COORD_BITS;
    localparam int MAX_WAIT      = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED   = 200;
    localparam int LONG_HOLD     = 300;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct {
        t_coord ax, ay, bx, by, cx, cy;
        t_coord min_x, min_y, max_x, max_y;
    } t_shape_pair;

    typedef struct {
        longint x;
        longint y;
    } t_point;

    typedef struct {
        t_shape_pair pair;
        bit          overlaps;
        int          seq;
    } t_overlap_expect;

    typedef enum int {
        MIX_CLUSTER,
        MIX_WIDE,
        MIX_FLAT,
        MIX_FLIPPED,
        MIX_EXTREME
    } t_shape_mix;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_coord i_tri_ax, i_tri_ay, i_tri_bx, i_tri_by, i_tri_cx, i_tri_cy;
    t_coord i_rect_min_x, i_rect_min_y, i_rect_max_x, i_rect_max_y;
    logic   o_out_valid;
    logic   i_out_ready;
    logic   o_overlaps;

    t_overlap_expect expected_overlaps[$];
    int sent_count     = 0;
    int mismatch_count = 0;
    int rx_hold_cycles = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;

    triangle_rectangle_overlap_test #(
        .COORD_BITS(CW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_tri_ax    (i_tri_ax),
        .i_tri_ay    (i_tri_ay),
        .i_tri_bx    (i_tri_bx),
        .i_tri_by    (i_tri_by),
        .i_tri_cx    (i_tri_cx),
        .i_tri_cy    (i_tri_cy),
        .i_rect_min_x(i_rect_min_x),
        .i_rect_min_y(i_rect_min_y),
        .i_rect_max_x(i_rect_max_x),
        .i_rect_max_y(i_rect_max_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_overlaps  (o_overlaps)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Overlap predictor: exact signs on 64-bit integers
    // ------------------------------------------------------------------
    function automatic int sign_of(input longint v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    // Sign of (b - a) x (p - a)
    function automatic int turn_sign(input t_point a, b, p);
        return sign_of((b.x - a.x) * (p.y - a.y) - (p.x - a.x) * (b.y - a.y));
    endfunction

    // Both turns nonzero and of equal sign
    function automatic bit strictly_same_side(input t_point p, q, a, b);
        return turn_sign(a, b, p) * turn_sign(a, b, q) > 0;
    endfunction

    // Barycentric numerators against the determinant; flat triangle fails
    function automatic bit corner_in_triangle(input t_point t1, t2, t3, p);
        longint det, n1, n2, n3;
        int     sd;
        det = (t2.y - t3.y) * (t1.x - t3.x) + (t3.x - t2.x) * (t1.y - t3.y);
        n1  = (t2.y - t3.y) * (p.x - t3.x) + (t3.x - t2.x) * (p.y - t3.y);
        n2  = (t3.y - t1.y) * (p.x - t3.x) + (t1.x - t3.x) * (p.y - t3.y);
        n3  = det - n1 - n2;
        sd  = sign_of(det);
        if (sd == 0) return 1'b0;
        return sign_of(n1) * sd >= 0 && sign_of(n2) * sd >= 0 && sign_of(n3) * sd >= 0;
    endfunction

    function automatic bit side_crosses_triangle(input t_point t0, t1, t2, p0, p1);
        if (strictly_same_side(t0, t1, p0, p1) && strictly_same_side(t0, t2, p0, p1))
            return 1'b0;
        if (!strictly_same_side(p0, t2, t0, t1) && !strictly_same_side(p1, t2, t0, t1))
            return 1'b0;
        if (!strictly_same_side(p0, t0, t1, t2) && !strictly_same_side(p1, t0, t1, t2))
            return 1'b0;
        if (!strictly_same_side(p0, t1, t2, t0) && !strictly_same_side(p1, t1, t2, t0))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit predict_overlap(input t_shape_pair s);
        t_point a, b, c, lo, hi, ul, lr;
        a.x  = s.ax;    a.y  = s.ay;
        b.x  = s.bx;    b.y  = s.by;
        c.x  = s.cx;    c.y  = s.cy;
        lo.x = s.min_x; lo.y = s.min_y;
        hi.x = s.max_x; hi.y = s.max_y;
        if (a.x >= lo.x && a.x <= hi.x && a.y >= lo.y && a.y <= hi.y) return 1'b1;
        if (corner_in_triangle(a, b, c, lo)) return 1'b1;
        ul.x = lo.x; ul.y = hi.y;
        lr.x = hi.x; lr.y = lo.y;
        return side_crosses_triangle(a, b, c, lo, ul) || side_crosses_triangle(a, b, c, lo, lr)
            || side_crosses_triangle(a, b, c, hi, ul) || side_crosses_triangle(a, b, c, hi, lr);
    endfunction

    // ------------------------------------------------------------------
    // Pair construction
    // ------------------------------------------------------------------
    function automatic t_shape_pair pair_of(input int ax, ay, bx, by, cx, cy,
                                            x0, y0, x1, y1);
        t_shape_pair s;
        s.ax = t_coord'(ax);    s.ay = t_coord'(ay);
        s.bx = t_coord'(bx);    s.by = t_coord'(by);
        s.cx = t_coord'(cx);    s.cy = t_coord'(cy);
        s.min_x = t_coord'(x0); s.min_y = t_coord'(y0);
        s.max_x = t_coord'(x1); s.max_y = t_coord'(y1);
        return s;
    endfunction

    function automatic t_coord near_coord(input int center, spread);
        return t_coord'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Half the time a value at or next to a range limit or zero, else anything
    function automatic t_coord boundary_coord();
        if ($urandom_range(0, 1)) return t_coord'($urandom);
        case ($urandom_range(0, 6))
            0:       return COORD_MIN;
            1:       return t_coord'(COORD_MIN + 1);
            2:       return t_coord'(-1);
            3:       return '0;
            4:       return t_coord'(1);
            5:       return t_coord'(COORD_MAX - 1);
            default: return COORD_MAX;
        endcase
    endfunction

    function automatic t_shape_pair random_pair();
        t_shape_pair s;
        t_shape_mix  mix;
        int          pick, center_x, center_y, spread, dx, dy, k1, k2;
        bit [1:0]    flip;
        t_coord      t;
        pick = $urandom_range(0, 99);
        if (pick < 55)      mix = MIX_CLUSTER;
        else if (pick < 70) mix = MIX_WIDE;
        else if (pick < 80) mix = MIX_FLAT;
        else if (pick < 92) mix = MIX_FLIPPED;
        else                mix = MIX_EXTREME;

        // Start from a tight cluster so that touches and crossings are common
        center_x = int'($urandom_range(0, 60000)) - 30000;
        center_y = int'($urandom_range(0, 60000)) - 30000;
        spread   = 1 << $urandom_range(2, 10);
        s.ax     = near_coord(center_x, spread);
        s.ay     = near_coord(center_y, spread);
        s.bx     = near_coord(center_x, spread);
        s.by     = near_coord(center_y, spread);
        s.cx     = near_coord(center_x, spread);
        s.cy     = near_coord(center_y, spread);
        s.min_x  = near_coord(center_x, spread);
        s.min_y  = near_coord(center_y, spread);
        s.max_x  = t_coord'(int'(s.min_x) + int'($urandom_range(0, 2 * spread)));
        s.max_y  = t_coord'(int'(s.min_y) + int'($urandom_range(0, 2 * spread)));

        case (mix)
            MIX_WIDE: begin
                s.ax = t_coord'($urandom);    s.ay = t_coord'($urandom);
                s.bx = t_coord'($urandom);    s.by = t_coord'($urandom);
                s.cx = t_coord'($urandom);    s.cy = t_coord'($urandom);
                s.min_x = t_coord'($urandom); s.min_y = t_coord'($urandom);
                s.max_x = t_coord'($urandom); s.max_y = t_coord'($urandom);
            end
            MIX_FLAT: begin
                // collinear vertices: zero determinant
                dx   = int'($urandom_range(0, 16)) - 8;
                dy   = int'($urandom_range(0, 16)) - 8;
                k1   = int'($urandom_range(0, 40)) - 20;
                k2   = int'($urandom_range(0, 40)) - 20;
                s.bx = t_coord'(int'(s.ax) + k1 * dx);
                s.by = t_coord'(int'(s.ay) + k1 * dy);
                s.cx = t_coord'(int'(s.ax) + k2 * dx);
                s.cy = t_coord'(int'(s.ay) + k2 * dy);
            end
            MIX_FLIPPED: begin
                flip = 2'($urandom_range(1, 3));
                if (flip[0]) begin
                    t = s.min_x; s.min_x = s.max_x; s.max_x = t;
                end
                if (flip[1]) begin
                    t = s.min_y; s.min_y = s.max_y; s.max_y = t;
                end
            end
            MIX_EXTREME: begin
                s.ax = boundary_coord();    s.ay = boundary_coord();
                s.bx = boundary_coord();    s.by = boundary_coord();
                s.cx = boundary_coord();    s.cy = boundary_coord();
                s.min_x = boundary_coord(); s.min_y = boundary_coord();
                s.max_x = boundary_coord(); s.max_y = boundary_coord();
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Offer one request after a random gap; hold it until accepted
    task automatic send_pair(input t_shape_pair s);
        int              gap;
        t_overlap_expect e;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_tri_ax     <= s.ax;
        i_tri_ay     <= s.ay;
        i_tri_bx     <= s.bx;
        i_tri_by     <= s.by;
        i_tri_cx     <= s.cx;
        i_tri_cy     <= s.cy;
        i_rect_min_x <= s.min_x;
        i_rect_min_y <= s.min_y;
        i_rect_max_x <= s.max_x;
        i_rect_max_y <= s.max_y;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        e.pair     = s;
        e.overlaps = predict_overlap(s);
        e.seq      = sent_count;
        sent_count++;
        expected_overlaps.insert(expected_overlaps.size(), e);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_overlaps.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, optional long hold, in-order check
    // ------------------------------------------------------------------
    initial begin : result_sink
        int              stall;
        t_overlap_expect e;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (expected_overlaps.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, overlaps %b",
                                          o_overlaps));
            end else begin
                e = expected_overlaps.pop_front();
                if (o_overlaps !== e.overlaps)
                    report_mismatch($sformatf(
                        "request %0d: overlaps %b exp %b tri (%0d,%0d) (%0d,%0d) (%0d,%0d) %s",
                        e.seq, o_overlaps, e.overlaps, e.pair.ax, e.pair.ay, e.pair.bx,
                        e.pair.by, e.pair.cx, e.pair.cy,
                        $sformatf("rect (%0d,%0d)-(%0d,%0d)", e.pair.min_x, e.pair.min_y,
                                  e.pair.max_x, e.pair.max_y)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // vertex A inside, on the max corner, on the min corner
        send_pair(pair_of(10, 10, 100, 200, -50, 300, 0, 0, 20, 20));
        send_pair(pair_of(20, 20, 40, 90, 90, 40, 0, 0, 20, 20));
        send_pair(pair_of(0, 0, -5, -50, -50, -5, 0, 0, 20, 20));
        // box inside a large triangle, both windings
        send_pair(pair_of(-1000, -1000, 1000, -1000, 0, 1000, -10, -10, 10, 10));
        send_pair(pair_of(-1000, -1000, 0, 1000, 1000, -1000, -10, -10, 10, 10));
        // min corner exactly on a triangle side
        send_pair(pair_of(-100, 0, 100, 0, 0, 100, 0, 0, 5, 5));
        send_pair(pair_of(-10, 0, 20, 0, 5, -10, 0, 0, 10, 10));
        // thin sliver through the box: only side crossings can catch it
        send_pair(pair_of(-100, 5, 100, 4, 100, 6, 0, 0, 10, 10));
        // disjoint
        send_pair(pair_of(100, 100, 200, 100, 150, 200, 0, 0, 10, 10));
        // flat triangles: collinear through the box, a lone point out and in
        send_pair(pair_of(-100, 5, 100, 5, 0, 5, 0, 0, 10, 10));
        send_pair(pair_of(-100, -100, 100, 100, 50, 50, 0, 0, 10, 10));
        send_pair(pair_of(50, 50, 50, 50, 50, 50, 0, 0, 10, 10));
        send_pair(pair_of(5, 5, 5, 5, 5, 5, 0, 0, 10, 10));
        // inverted boxes
        send_pair(pair_of(5, 5, 100, 5, 5, 100, 10, 0, 0, 10));
        send_pair(pair_of(-1000, -1000, 1000, -1000, 0, 1000, 10, 10, -10, -10));
        // vertex B touching a box corner only
        send_pair(pair_of(30, 30, 10, 10, 30, 10, 0, 0, 10, 10));
        // range extremes
        send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, 32767,
                          -32768, -32768, 32767, 32767));
        send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767));
        send_pair(pair_of(32767, 32767, -32768, 32767, 32767, -32768,
                          -32768, -32768, -32000, -32000));
    endtask

    task automatic test_random_shapes(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_steady_stream(input int count);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (count) send_pair(random_pair());
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_one_side_steady(input int count);
        tx_steady = 1'b1;
        repeat (count) send_pair(random_pair());
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        repeat (count) send_pair(random_pair());
        rx_steady = 1'b0;
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_result_backpressure(input int count);
        rx_hold_cycles = LONG_HOLD;
        tx_steady      = 1'b1;
        repeat (count) send_pair(random_pair());
        tx_steady      = 1'b0;
    endtask

    // Each burst ends with every result collected
    task automatic test_drained_bursts(input int bursts, input int count);
        repeat (bursts) begin
            repeat (count) send_pair(random_pair());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_tri_ax     <= '0;
        i_tri_ay     <= '0;
        i_tri_bx     <= '0;
        i_tri_by     <= '0;
        i_tri_cx     <= '0;
        i_tri_cy     <= '0;
        i_rect_min_x <= '0;
        i_rect_min_y <= '0;
        i_rect_max_x <= '0;
        i_rect_max_y <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_shapes(700);
        test_steady_stream(150);
        test_one_side_steady(50);
        test_result_backpressure(80);
        test_drained_bursts(3, 40);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Bound the run well above the slowest legal schedule
    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tro_pkg.sv
rtl/core/tro_cross_sign.sv
rtl/core/tro_overlap_core.sv
rtl/core/triangle_rectangle_overlap_test.sv
sim/triangle_rectangle_overlap_test_test.sv
